>>> design/vlmr_pkg.sv
package vlmr_pkg;

    localparam int LEN_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int RING_MAX  = 2044;

    localparam logic [LEN_W-1:0] HDR_BYTES = LEN_W'(4);

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECV  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BUF_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG  = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_ROOM,
        ST_BAD_LEN,
        ST_EMPTY,
        ST_SEQ_ERR
    } status_t;

endpackage

>>> design/variable_length_message_ring_top.sv
// Channel  | Direction | Handshake              | Payload
// s_       | in        | s_valid / s_ready      | s_mode, s_msg_len, s_data_byte
// m_       | out       | m_valid / m_ready      | m_status, m_data_byte_out, m_msg_size,
//          |           |                        | m_last, m_free_bytes
// cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item at a time. A start send, send byte or error item is taken in S_IDLE and has its
// result registered from S_EXEC; a receive with a message to read runs through S_EXEC and
// S_BYTE, and S_HDR as well when it opens a message, since the header and body words are
// read one after the other (each into a registered read word).
// Reset is synchronous on aresetn low; the message memory is not cleared.
// A held result stalls the next item in S_EXEC, S_HDR or S_BYTE; no input is taken meanwhile.
module variable_length_message_ring_top #(
    parameter int BUF_BYTES = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [vlmr_pkg::MODE_W-1:0]     s_mode,
    input  logic [vlmr_pkg::LEN_W-1:0]      s_msg_len,
    input  logic [vlmr_pkg::BYTE_W-1:0]     s_data_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [vlmr_pkg::STATUS_W-1:0]   m_status,
    output logic [vlmr_pkg::BYTE_W-1:0]     m_data_byte_out,
    output logic [vlmr_pkg::LEN_W-1:0]      m_msg_size,
    output logic                            m_last,
    output logic [vlmr_pkg::LEN_W-1:0]      m_free_bytes,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vlmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vlmr_pkg::LEN_W-1:0]      cfg_data
);
    import vlmr_pkg::*;

    localparam int WORDS    = (BUF_BYTES + 3) / 4;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW       = AW + 2;
    localparam int CW       = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int CAP_RAW  = BUF_BYTES - (BUF_BYTES % 4);
    localparam int CAP_CLIP = (CAP_RAW > RING_MAX) ? RING_MAX : CAP_RAW;
    localparam logic [LEN_W-1:0] RING_CAP   = LEN_W'(CAP_CLIP);
    localparam logic [LEN_W-1:0] RESET_BUF  = LEN_W'(1024);
    localparam logic [LEN_W-1:0] RESET_RING =
        ((RESET_BUF & ~LEN_W'(3)) > RING_CAP) ? RING_CAP : (RESET_BUF & ~LEN_W'(3));

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HDR, S_BYTE} state_t;

    function automatic logic [LEN_W-1:0] ring_of(input logic [LEN_W-1:0] b);
        logic [LEN_W-1:0] s;
        s = b & ~LEN_W'(3);
        return (s > RING_CAP) ? RING_CAP : s;
    endfunction

    function automatic logic [PW-1:0] wrap_pos(input logic [CW-1:0] p,
                                               input logic [LEN_W-1:0] ring);
        return (p >= CW'(ring)) ? '0 : p[PW-1:0];
    endfunction

    function automatic logic [CW-1:0] pad4(input logic [CW-1:0] p);
        logic [CW-1:0] q;
        q = p + CW'(3);
        return {q[CW-1:2], 2'b00};
    endfunction

    function automatic logic [LEN_W:0] rec_bytes(input logic [LEN_W-1:0] n);
        logic [LEN_W:0] q;
        q = {1'b0, n} + (LEN_W+1)'(3);
        return {q[LEN_W:2], 2'b00} + (LEN_W+1)'(HDR_BYTES);
    endfunction

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rdata_reg;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] dbyte_reg;

    logic [LEN_W-1:0]  ring_reg, ring_next;
    logic [LEN_W-1:0]  max_msg_reg, max_msg_next;
    logic [PW-1:0]     read_pos_reg, read_pos_next;
    logic [PW-1:0]     write_pos_reg, write_pos_next;
    logic [PW-1:0]     recv_pos_reg, recv_pos_next;
    logic [LEN_W-1:0]  free_reg, free_next;
    logic [LEN_W-1:0]  send_left_reg, send_left_next;
    logic [LEN_W-1:0]  send_len_reg, send_len_next;
    logic [LEN_W-1:0]  recv_left_reg, recv_left_next;
    logic [LEN_W-1:0]  recv_len_reg, recv_len_next;
    logic [7:0]        complete_reg, complete_next;

    logic              m_valid_reg, m_valid_next;
    status_t           status_reg, status_next;
    logic [BYTE_W-1:0] dout_reg, dout_next;
    logic [LEN_W-1:0]  size_reg, size_next;
    logic              last_reg, last_next;

    logic              slot_free;
    logic              wr_en, rd_en;
    logic [3:0]        wr_be;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data;
    logic [PW-1:0]     p1, hdr_pos;
    logic [LEN_W-1:0]  hdr_len;
    logic [LEN_W:0]    need;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_data_byte_out = dout_reg;
    assign m_msg_size      = size_reg;
    assign m_last          = last_reg;
    assign m_free_bytes    = free_reg;

    always_comb begin
        state_next     = state_reg;
        ring_next      = ring_reg;
        max_msg_next   = max_msg_reg;
        read_pos_next  = read_pos_reg;
        write_pos_next = write_pos_reg;
        recv_pos_next  = recv_pos_reg;
        free_next      = free_reg;
        send_left_next = send_left_reg;
        send_len_next  = send_len_reg;
        recv_left_next = recv_left_reg;
        recv_len_next  = recv_len_reg;
        complete_next  = complete_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        dout_next      = dout_reg;
        size_next      = size_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_be          = '0;
        wr_addr        = write_pos_reg[PW-1:2];
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        p1             = '0;
        hdr_len        = rdata_reg[LEN_W-1:0];
        hdr_pos        = wrap_pos(CW'(read_pos_reg) + CW'(HDR_BYTES), ring_reg);
        need           = rec_bytes(len_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                    dout_next  = '0;
                    size_next  = '0;
                    last_next  = 1'b0;
                    unique case (mode_reg)
                        MODE_START: begin
                            m_valid_next = 1'b1;
                            size_next    = len_reg;
                            if (send_left_reg != '0) begin
                                status_next = ST_SEQ_ERR;
                            end else if (len_reg == '0 || len_reg > max_msg_reg) begin
                                status_next = ST_BAD_LEN;
                            end else if (need > {1'b0, free_reg}) begin
                                status_next = ST_NO_ROOM;
                            end else begin
                                status_next    = ST_OK;
                                free_next      = free_reg - need[LEN_W-1:0];
                                wr_en          = 1'b1;
                                wr_be          = 4'b1111;
                                wr_data        = WORD_W'(len_reg);
                                write_pos_next = wrap_pos(CW'(write_pos_reg) +
                                                          CW'(HDR_BYTES), ring_reg);
                                send_left_next = len_reg;
                                send_len_next  = len_reg;
                            end
                        end
                        MODE_BYTE: begin
                            m_valid_next = 1'b1;
                            if (send_left_reg != '0) begin
                                status_next = ST_OK;
                                wr_en       = 1'b1;
                                wr_be       = 4'b0001 << write_pos_reg[1:0];
                                wr_data     = {4{dbyte_reg}};
                                p1 = wrap_pos(CW'(write_pos_reg) + CW'(1), ring_reg);
                                write_pos_next = p1;
                                send_left_next = send_left_reg - LEN_W'(1);
                                size_next      = send_len_reg;
                                if (send_left_reg == LEN_W'(1)) begin
                                    write_pos_next = wrap_pos(pad4(CW'(p1)), ring_reg);
                                    complete_next  = complete_reg + 8'd1;
                                    last_next      = 1'b1;
                                end
                            end else begin
                                status_next = ST_SEQ_ERR;
                            end
                        end
                        MODE_RECV: begin
                            if (recv_left_reg != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = recv_pos_reg[PW-1:2];
                                state_next = S_BYTE;
                            end else if (complete_reg != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = read_pos_reg[PW-1:2];
                                state_next = S_HDR;
                            end else begin
                                m_valid_next = 1'b1;
                                status_next  = ST_EMPTY;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            status_next  = ST_SEQ_ERR;
                        end
                    endcase
                end
            end
            S_HDR: begin
                if (hdr_len != '0) begin
                    recv_len_next  = hdr_len;
                    recv_left_next = hdr_len;
                    recv_pos_next  = hdr_pos;
                    rd_en          = 1'b1;
                    rd_addr        = hdr_pos[PW-1:2];
                    state_next     = S_BYTE;
                end else if (slot_free) begin
                    recv_len_next  = '0;
                    recv_left_next = '0;
                    recv_pos_next  = hdr_pos;
                    complete_next  = complete_reg - 8'd1;
                    m_valid_next   = 1'b1;
                    status_next    = ST_EMPTY;
                    dout_next      = '0;
                    size_next      = '0;
                    last_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_BYTE: begin
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    status_next    = ST_OK;
                    dout_next      = rdata_reg[{recv_pos_reg[1:0], 3'b000} +: BYTE_W];
                    size_next      = recv_len_reg;
                    last_next      = 1'b0;
                    p1 = wrap_pos(CW'(recv_pos_reg) + CW'(1), ring_reg);
                    recv_pos_next  = p1;
                    recv_left_next = recv_left_reg - LEN_W'(1);
                    if (recv_left_reg == LEN_W'(1)) begin
                        free_next     = LEN_W'({1'b0, free_reg} + rec_bytes(recv_len_reg));
                        read_pos_next = wrap_pos(pad4(CW'(p1)), ring_reg);
                        recv_pos_next = '0;
                        complete_next = complete_reg - 8'd1;
                        last_next     = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
        endcase

        if (cfg_valid) begin
            if (cfg_index == CFG_BUF_SIZE) begin
                ring_next      = ring_of(cfg_data);
                free_next      = ring_of(cfg_data);
                read_pos_next  = '0;
                write_pos_next = '0;
                recv_pos_next  = '0;
                send_left_next = '0;
                send_len_next  = '0;
                recv_left_next = '0;
                recv_len_next  = '0;
                complete_next  = '0;
            end else if (cfg_index == CFG_MAX_MSG) begin
                max_msg_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int i = 0; i < 4; i++) begin
                if (wr_be[i]) begin
                    mem[wr_addr][i*BYTE_W +: BYTE_W] <= wr_data[i*BYTE_W +: BYTE_W];
                end
            end
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ring_reg      <= RESET_RING;
            max_msg_reg   <= RESET_BUF;
            read_pos_reg  <= '0;
            write_pos_reg <= '0;
            recv_pos_reg  <= '0;
            free_reg      <= RESET_RING;
            send_left_reg <= '0;
            send_len_reg  <= '0;
            recv_left_reg <= '0;
            recv_len_reg  <= '0;
            complete_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ring_reg      <= ring_next;
            max_msg_reg   <= max_msg_next;
            read_pos_reg  <= read_pos_next;
            write_pos_reg <= write_pos_next;
            recv_pos_reg  <= recv_pos_next;
            free_reg      <= free_next;
            send_left_reg <= send_left_next;
            send_len_reg  <= send_len_next;
            recv_left_reg <= recv_left_next;
            recv_len_reg  <= recv_len_next;
            complete_reg  <= complete_next;
            m_valid_reg   <= m_valid_next;
        end
        if (s_valid && s_ready) begin
            mode_reg  <= s_mode;
            len_reg   <= s_msg_len;
            dbyte_reg <= s_data_byte;
        end
        status_reg <= status_next;
        dout_reg   <= dout_next;
        size_reg   <= size_next;
        last_reg   <= last_next;
    end

    a_free_within_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= ring_reg)
        else $error("free count exceeds ring size");

    a_recv_needs_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        recv_left_reg != '0 |-> complete_reg != '0)
        else $error("receive open with no complete message");

    a_recv_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        recv_left_reg <= recv_len_reg)
        else $error("receive count beyond message length");

    a_byte_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BYTE && $past(state_reg) != S_BYTE) |-> $past(rd_en))
        else $error("byte state entered without a memory read");

    a_result_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BYTE && slot_free) |=> m_valid_reg && state_reg == S_IDLE)
        else $error("receive byte did not produce a result");

endmodule
